@@ rtl/dsgc_pkg.sv @@
// Shared constants and types for the disk sample grid conflict checker.
package dsgc_pkg;

  localparam int GRID_SIDE_DEF      = 64;
  localparam int SLOTS_PER_CELL_DEF = 4;

  // Coordinate format is fixed by the port widths: Q0.16.
  localparam int COORD_BITS   = 16;
  localparam int PRI_W        = 16;
  localparam int RANGE_W      = 16;
  localparam int CELL_FIELD_W = 12;
  localparam int SLOT_FIELD_W = 2;

  localparam logic [RANGE_W-1:0] SEARCH_RANGE_RST = 16'd1024;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_INVAL  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

endpackage

@@ rtl/dsgc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module dsgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/disk_sample_grid_conflict_check_top.sv @@
// Top level of the disk sample grid conflict checker: grid store, sequencer and distance unit.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------------------
//   in       | in_valid, in_stall | in_cmd, in_coord_x, in_coord_y, in_point_priority,
//            |                    | in_target_cell, in_target_slot
//   out      | out_valid,out_stall| out_status, out_clear, out_exact_match, out_placed_cell,
//            |                    | out_placed_slot
//   cfg      | cfg_we             | cfg_wdata (search range)
//
// A query scans each cell covered by the search window: at most 9 cells when the range
// is below one cell width.
// The query time is set by the cell scan: the slot banks are read at one cell address per
// cycle and a three-stage distance pipeline must drain before the answer is known.
// After reset the cell fill memory is swept to zero, one cell per cycle, over every
// cell of the grid; in_stall stays high during that sweep.
// One beat is worked on at a time. A finished result sits in the output register while
// the next input beat is accepted; a result only waits for a stalled output register.
module disk_sample_grid_conflict_check_top
  import dsgc_pkg::*;
#(
  parameter int GRID_SIDE      = GRID_SIDE_DEF,
  parameter int SLOTS_PER_CELL = SLOTS_PER_CELL_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration port.
  input  logic                    cfg_we,
  input  logic [RANGE_W-1:0]      cfg_wdata,
  // Input channel.
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_cmd,
  input  logic [COORD_BITS-1:0]   in_coord_x,
  input  logic [COORD_BITS-1:0]   in_coord_y,
  input  logic [PRI_W-1:0]        in_point_priority,
  input  logic [CELL_FIELD_W-1:0] in_target_cell,
  input  logic [SLOT_FIELD_W-1:0] in_target_slot,
  // Result channel.
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_status,
  output logic                    out_clear,
  output logic                    out_exact_match,
  output logic [CELL_FIELD_W-1:0] out_placed_cell,
  output logic [SLOT_FIELD_W-1:0] out_placed_slot
);

  // Derived sizes.
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int LINE_W     = $clog2(GRID_SIDE);
  localparam int FILL_W     = $clog2(SLOTS_PER_CELL + 1);
  localparam int PROD_W     = COORD_BITS + LINE_W + 1;
  localparam int DATA_W     = PRI_W + 2 * COORD_BITS;
  localparam int SQ_W       = 2 * COORD_BITS;

  localparam logic [CELL_W-1:0]     GRID_SIDE_C = CELL_W'(GRID_SIDE);
  localparam logic [CELL_W-1:0]     LAST_CELL   = CELL_W'(CELL_COUNT - 1);
  localparam logic [FILL_W-1:0]     SLOTS_FILL  = FILL_W'(SLOTS_PER_CELL);
  localparam logic [COORD_BITS:0]   COORD_MAX   = (COORD_BITS + 1)'((1 << COORD_BITS) - 1);

  typedef enum logic [11:0] {
    ST_CLEAR     = 12'b0000_0000_0001,
    ST_IDLE      = 12'b0000_0000_0010,
    ST_INS_LINE  = 12'b0000_0000_0100,
    ST_INS_CELL  = 12'b0000_0000_1000,
    ST_INS_READ  = 12'b0000_0001_0000,
    ST_INS_WRITE = 12'b0000_0010_0000,
    ST_INVAL     = 12'b0000_0100_0000,
    ST_Q_BOUND   = 12'b0000_1000_0000,
    ST_Q_LINE    = 12'b0001_0000_0000,
    ST_Q_SCAN    = 12'b0010_0000_0000,
    ST_Q_DRAIN   = 12'b0100_0000_0000,
    ST_DONE      = 12'b1000_0000_0000
  } state_t;

  // Column or row of a coordinate: floor(c * GRID_SIDE / 2^COORD_BITS).
  function automatic logic [LINE_W-1:0] line_of(input logic [COORD_BITS-1:0] c);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(c) * PROD_W'(GRID_SIDE);
    return prod[COORD_BITS +: LINE_W];
  endfunction

  state_t state_r, state_nxt;

  logic [RANGE_W-1:0] search_range_r;
  logic [CELL_W-1:0]  clr_idx_r;

  // Latched command.
  cmd_t                    cmd_r;
  logic [COORD_BITS-1:0]   px_r, py_r;
  logic [PRI_W-1:0]        pri_r;
  logic [CELL_FIELD_W-1:0] tcell_r;
  logic [SLOT_FIELD_W-1:0] tslot_r;

  // Insert path.
  logic [LINE_W-1:0] lx_r, ly_r;
  logic [CELL_W-1:0] cell_r;

  // Query window and scan counters.
  logic [COORD_BITS-1:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic [SQ_W-1:0]       r2_r;
  logic [LINE_W-1:0]     c1_r, r0_r, r1_r;
  logic [LINE_W-1:0]     col_r, row_r;

  // Distance pipeline.
  logic                  v_rd_r, v_b_r, v_c_r;
  logic [COORD_BITS-1:0] dx_r [SLOTS_PER_CELL];
  logic [COORD_BITS-1:0] dy_r [SLOTS_PER_CELL];
  logic [SQ_W-1:0]       sx_r [SLOTS_PER_CELL];
  logic [SQ_W-1:0]       sy_r [SLOTS_PER_CELL];
  logic [SLOTS_PER_CELL-1:0] ok_b_r, ok_c_r;
  logic                  conflict_r, same_r;
  logic                  hit_conf, hit_same;

  // Pending result and output register.
  logic                    res_status_r;
  logic [CELL_FIELD_W-1:0] res_pcell_r;
  logic [SLOT_FIELD_W-1:0] res_pslot_r;
  logic                    out_valid_r;
  logic                    out_status_r, out_clear_r, out_exact_match_r;
  logic [CELL_FIELD_W-1:0] out_placed_cell_r;
  logic [SLOT_FIELD_W-1:0] out_placed_slot_r;

  // Memory ports.
  logic [CELL_W-1:0] rd_addr, scan_addr, tcell_addr, vld_waddr;
  logic              fill_we;
  logic [CELL_W-1:0] fill_waddr;
  logic [FILL_W-1:0] fill_wdata, fill_rdata;
  logic              cell_full, inval_ok, vld_wdata;
  logic [SLOTS_PER_CELL-1:0] data_we, vld_we, vld_rdata;
  logic [DATA_W-1:0] bank_rdata [SLOTS_PER_CELL];

  logic in_acc, out_load, out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_DONE) && out_free;

  assign scan_addr  = CELL_W'(row_r) * GRID_SIDE_C + CELL_W'(col_r);
  assign rd_addr    = (state_r == ST_Q_SCAN) ? scan_addr : cell_r;
  assign tcell_addr = CELL_W'(tcell_r);
  assign cell_full  = (fill_rdata >= SLOTS_FILL);
  assign inval_ok   = (int'(tcell_r) < CELL_COUNT) && (int'(tslot_r) < SLOTS_PER_CELL);

  // The fill memory is either being swept clear or updated by an insert.
  assign fill_we    = (state_r == ST_CLEAR) || ((state_r == ST_INS_WRITE) && !cell_full);
  assign fill_waddr = (state_r == ST_CLEAR) ? clr_idx_r : cell_r;
  assign fill_wdata = (state_r == ST_CLEAR) ? '0 : FILL_W'(fill_rdata + 1'b1);

  // Insert marks the slot valid; invalidate clears it.
  assign vld_waddr = (state_r == ST_INVAL) ? tcell_addr : cell_r;
  assign vld_wdata = (state_r != ST_INVAL);

  dsgc_ram #(
    .WIDTH (FILL_W),
    .DEPTH (CELL_COUNT)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (rd_addr),
    .rdata (fill_rdata)
  );

  // One bank per slot position, so a whole cell is read in a single access.
  for (genvar k = 0; k < SLOTS_PER_CELL; k++) begin : g_bank
    assign data_we[k] = (state_r == ST_INS_WRITE) && !cell_full &&
                        (fill_rdata == FILL_W'(k));
    assign vld_we[k]  = data_we[k] ||
                        ((state_r == ST_INVAL) && inval_ok && (int'(tslot_r) == k));

    dsgc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CELL_COUNT)
    ) u_data_ram (
      .clk   (clk),
      .we    (data_we[k]),
      .waddr (cell_r),
      .wdata ({pri_r, py_r, px_r}),
      .raddr (rd_addr),
      .rdata (bank_rdata[k])
    );

    dsgc_ram #(
      .WIDTH (1),
      .DEPTH (CELL_COUNT)
    ) u_vld_ram (
      .clk   (clk),
      .we    (vld_we[k]),
      .waddr (vld_waddr),
      .wdata (vld_wdata),
      .raddr (rd_addr),
      .rdata (vld_rdata[k])
    );
  end

  // Final stage of the distance unit: combine the squared terms of every lane.
  always_comb begin
    logic [SQ_W:0] d2;
    hit_conf = 1'b0;
    hit_same = 1'b0;
    for (int k = 0; k < SLOTS_PER_CELL; k++) begin
      d2 = (SQ_W + 1)'(sx_r[k]) + (SQ_W + 1)'(sy_r[k]);
      if (ok_c_r[k]) begin
        if (d2 == '0) begin
          hit_same = 1'b1;
        end else if (d2 < (SQ_W + 1)'(r2_r)) begin
          hit_conf = 1'b1;
        end
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd_t'(in_cmd))
            CMD_INSERT: state_nxt = ST_INS_LINE;
            CMD_QUERY:  state_nxt = ST_Q_BOUND;
            CMD_INVAL:  state_nxt = ST_INVAL;
            CMD_NOP:    state_nxt = ST_DONE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_INS_LINE:  state_nxt = ST_INS_CELL;
      ST_INS_CELL:  state_nxt = ST_INS_READ;
      ST_INS_READ:  state_nxt = ST_INS_WRITE;
      ST_INS_WRITE: state_nxt = ST_DONE;
      ST_INVAL:     state_nxt = ST_DONE;
      ST_Q_BOUND:   state_nxt = ST_Q_LINE;
      ST_Q_LINE:    state_nxt = ST_Q_SCAN;
      ST_Q_SCAN: begin
        if ((row_r == r1_r) && (col_r == c1_r)) begin
          state_nxt = ST_Q_DRAIN;
        end
      end
      ST_Q_DRAIN: begin
        if (!v_rd_r && !v_b_r && !v_c_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      search_range_r <= SEARCH_RANGE_RST;
      clr_idx_r      <= '0;
      out_valid_r    <= 1'b0;
      v_rd_r         <= 1'b0;
      v_b_r          <= 1'b0;
      v_c_r          <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        search_range_r <= cfg_wdata;
      end
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= CELL_W'(clr_idx_r + 1'b1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      v_rd_r <= (state_r == ST_Q_SCAN);
      v_b_r  <= v_rd_r;
      v_c_r  <= v_b_r;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r        <= cmd_t'(in_cmd);
      px_r         <= in_coord_x;
      py_r         <= in_coord_y;
      pri_r        <= in_point_priority;
      tcell_r      <= in_target_cell;
      tslot_r      <= in_target_slot;
      res_status_r <= 1'b0;
      res_pcell_r  <= '0;
      res_pslot_r  <= '0;
      conflict_r   <= 1'b0;
      same_r       <= 1'b0;
    end

    if (state_r == ST_INS_LINE) begin
      lx_r <= line_of(px_r);
      ly_r <= line_of(py_r);
    end
    if (state_r == ST_INS_CELL) begin
      cell_r <= CELL_W'(ly_r) * GRID_SIDE_C + CELL_W'(lx_r);
    end
    if (state_r == ST_INS_WRITE) begin
      res_pcell_r <= CELL_FIELD_W'(cell_r);
      if (cell_full) begin
        res_status_r <= 1'b1;
      end else begin
        res_pslot_r <= SLOT_FIELD_W'(fill_rdata);
      end
    end

    // Window clipped to the square, then converted to cell lines.
    if (state_r == ST_Q_BOUND) begin
      xlo_r <= (px_r > search_range_r) ? px_r - search_range_r : '0;
      ylo_r <= (py_r > search_range_r) ? py_r - search_range_r : '0;
      xhi_r <= ((COORD_BITS + 1)'(px_r) + (COORD_BITS + 1)'(search_range_r) > COORD_MAX) ?
               COORD_MAX[COORD_BITS-1:0] : COORD_BITS'(px_r + search_range_r);
      yhi_r <= ((COORD_BITS + 1)'(py_r) + (COORD_BITS + 1)'(search_range_r) > COORD_MAX) ?
               COORD_MAX[COORD_BITS-1:0] : COORD_BITS'(py_r + search_range_r);
      r2_r  <= SQ_W'(search_range_r) * SQ_W'(search_range_r);
    end
    if (state_r == ST_Q_LINE) begin
      c1_r  <= line_of(xhi_r);
      r0_r  <= line_of(ylo_r);
      r1_r  <= line_of(yhi_r);
      col_r <= line_of(xlo_r);
      row_r <= line_of(ylo_r);
    end
    if (state_r == ST_Q_SCAN) begin
      if (row_r == r1_r) begin
        row_r <= r0_r;
        col_r <= LINE_W'(col_r + 1'b1);
      end else begin
        row_r <= LINE_W'(row_r + 1'b1);
      end
    end

    // Lane pipeline: absolute differences, then squares, then the compare above.
    for (int k = 0; k < SLOTS_PER_CELL; k++) begin
      dx_r[k] <= (px_r > bank_rdata[k][COORD_BITS-1:0]) ?
                 px_r - bank_rdata[k][COORD_BITS-1:0] :
                 bank_rdata[k][COORD_BITS-1:0] - px_r;
      dy_r[k] <= (py_r > bank_rdata[k][2*COORD_BITS-1:COORD_BITS]) ?
                 py_r - bank_rdata[k][2*COORD_BITS-1:COORD_BITS] :
                 bank_rdata[k][2*COORD_BITS-1:COORD_BITS] - py_r;
      ok_b_r[k] <= vld_rdata[k] && (FILL_W'(k) < fill_rdata);
      sx_r[k]   <= SQ_W'(dx_r[k]) * SQ_W'(dx_r[k]);
      sy_r[k]   <= SQ_W'(dy_r[k]) * SQ_W'(dy_r[k]);
    end
    ok_c_r <= ok_b_r;

    if (v_c_r) begin
      if (hit_conf) begin
        conflict_r <= 1'b1;
      end
      if (hit_same) begin
        same_r <= 1'b1;
      end
    end

    if (out_load) begin
      out_status_r      <= res_status_r;
      out_clear_r       <= (cmd_r == CMD_QUERY) && !conflict_r;
      out_exact_match_r <= same_r;
      out_placed_cell_r <= res_pcell_r;
      out_placed_slot_r <= res_pslot_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_clear       = out_clear_r;
  assign out_exact_match = out_exact_match_r;
  assign out_placed_cell = out_placed_cell_r;
  assign out_placed_slot = out_placed_slot_r;

endmodule
